### sv/cile_pkg.sv
// ----------------------------------------------------------------------------
// cile_pkg
// Shared types and codes for the circular indexed list engine.
// ----------------------------------------------------------------------------
package cile_pkg;

  localparam int CileCapacity = 16;
  localparam int PosW         = 8;
  localparam int WordW        = 32;
  localparam int StatusW      = 2;
  localparam int CountOutW    = 5;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StRange = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [PosW-1:0]         position;
    logic signed [WordW-1:0] value;
  } cile_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] data;
    logic [StatusW-1:0]      status;
    logic [CountOutW-1:0]    count;
  } cile_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_WR,
    S_REM_WORD,
    S_REM_RD,
    S_REM_WR,
    S_MOD,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_OUT
  } cile_state_e;

endpackage

### sv/circular_indexed_list_engine.sv
// ----------------------------------------------------------------------------
// circular_indexed_list_engine
// Bounded ordered list of signed words with insert, remove, read and clear.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, single-port-read memory with a
// registered read, and a small sequencer moves entries one at a time. Each
// transaction is accepted only when the engine is idle and yields exactly one
// result. Insert and remove shift the entries after position p one at a time,
// each by a read followed by a write through the memory port. Read first
// reduces the position modulo the count in eight restoring compare-and-subtract
// steps of the modulo unit, then issues one memory read. Clear and every error
// go straight to the result. The result is then held until the output
// transaction completes. Entries that were never written are never read, so
// the memory needs no clearing pass.
module circular_indexed_list_engine
  import cile_pkg::*;
#(
  parameter int CAPACITY = CileCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cile_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cile_out_t out_data_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CmpW = (CW > PosW) ? CW : PosW;
  localparam int BitW = $clog2(PosW);

  cile_state_e              state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic signed [WordW-1:0]  val_q, val_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic [BitW-1:0]          bit_q, bit_d;
  cile_out_t                out_q, out_d;

  logic signed [WordW-1:0]  mem_q [CAPACITY];
  logic signed [WordW-1:0]  rd_data_q;
  logic                     mem_we, mem_re;
  logic [IW-1:0]            mem_waddr, mem_raddr;
  logic signed [WordW-1:0]  mem_wdata;

  logic [CW:0]              trial;
  logic [CW-1:0]            idx_dec, idx_inc;
  logic                     pos_gt_cnt, pos_ge_cnt, idx_gt_pos, idx_inc_lt_cnt;

  assign idx_dec        = idx_q - 1'b1;
  assign idx_inc        = idx_q + 1'b1;
  assign pos_gt_cnt     = CmpW'(pos_q) > CmpW'(cnt_q);
  assign pos_ge_cnt     = CmpW'(pos_q) >= CmpW'(cnt_q);
  assign idx_gt_pos     = CmpW'(idx_q) > CmpW'(pos_q);
  assign idx_inc_lt_cnt = (CW + 1)'(idx_inc) < (CW + 1)'(cnt_q);
  assign trial          = {rem_q, pos_q[bit_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    pos_q <= pos_d;
    val_q <= val_d;
    idx_q <= idx_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_raddr = idx_q[IW-1:0];
    mem_wdata = rd_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.op;
          pos_d   = in_data_i.position;
          val_d   = in_data_i.value;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        out_d.data   = '0;
        out_d.status = StOk;
        out_d.count  = CountOutW'(cnt_q);
        unique case (op_q)
          OpInsert: begin
            if (pos_gt_cnt) begin
              out_d.status = StRange;
              state_d      = S_OUT;
            end else if (cnt_q == CW'(CAPACITY)) begin
              out_d.status = StFull;
              state_d      = S_OUT;
            end else begin
              idx_d   = cnt_q;
              state_d = S_INS_RD;
            end
          end
          OpRemove: begin
            if (cnt_q == '0) begin
              out_d.status = StEmpty;
              state_d      = S_OUT;
            end else if (pos_ge_cnt) begin
              out_d.status = StRange;
              state_d      = S_OUT;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = pos_q[IW-1:0];
              idx_d     = CW'(pos_q);
              state_d   = S_REM_WORD;
            end
          end
          OpRead: begin
            if (cnt_q == '0) begin
              out_d.status = StEmpty;
              state_d      = S_OUT;
            end else begin
              rem_d   = '0;
              bit_d   = BitW'(PosW - 1);
              state_d = S_MOD;
            end
          end
          OpClear: begin
            cnt_d       = '0;
            out_d.count = '0;
            state_d     = S_OUT;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_INS_RD: begin
        if (idx_gt_pos) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[IW-1:0];
          state_d   = S_INS_WR;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = pos_q[IW-1:0];
          mem_wdata   = val_q;
          cnt_d       = cnt_q + 1'b1;
          out_d.count = CountOutW'(cnt_d);
          state_d     = S_OUT;
        end
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = S_INS_RD;
      end
      S_REM_WORD: begin
        out_d.data = rd_data_q;
        state_d    = S_REM_RD;
      end
      S_REM_RD: begin
        if (idx_inc_lt_cnt) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IW-1:0];
          state_d   = S_REM_WR;
        end else begin
          cnt_d       = cnt_q - 1'b1;
          out_d.count = CountOutW'(cnt_d);
          state_d     = S_OUT;
        end
      end
      S_REM_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_REM_RD;
      end
      S_MOD: begin
        if (trial >= (CW + 1)'(cnt_q)) begin
          rem_d = CW'(trial - (CW + 1)'(cnt_q));
        end else begin
          rem_d = CW'(trial);
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = S_RD_ISSUE;
        end
      end
      S_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = rem_q[IW-1:0];
        state_d   = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        out_d.data = rd_data_q;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

endmodule
